// ----- rtl/core/pli_pkg.sv -----
// Package for the positional list block: field widths, command and status
// codes, datapath operation type and command struct.
// No dependencies.
package pli_pkg;

    localparam int CMD_W         = 2;
    localparam int POS_W         = 5;
    localparam int VAL_W         = 32;
    localparam int STAT_W        = 2;
    localparam int CNT_OUT_W     = 5;
    localparam int LIST_DEPTH_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [1:0] {
        DP_NOP,
        DP_INSERT,
        DP_DELETE,
        DP_ROTATE
    } t_dp_op;

    typedef struct packed {
        t_dp_op                   op;
        logic [POS_W-1:0]         pos;
        logic signed [VAL_W-1:0]  value;
    } t_dp_cmd;

endpackage

// ----- rtl/core/pli_stream_if.sv -----
// Valid/ready stream interfaces for the positional list block:
// command channel and result channel. Depends on pli_pkg.
interface pli_in_if;
    import pli_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

interface pli_out_if;
    import pli_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic signed [VAL_W-1:0] element;
    logic                    element_valid;
    logic                    last;

    modport source (output valid, output status, output entry_count, output element,
                    output element_valid, output last, input ready);
    modport sink   (input valid, input status, input entry_count, input element,
                    input element_valid, input last, output ready);
endinterface

// ----- rtl/core/positional_list_insert_delete_top.sv -----
// Positional list top: a bounded ordered list with insert, delete and display.
// Insert/delete: result registered in the next cycle; one per cycle unless output stalls.
// Display: one result per entry, one per cycle from the head cell in the display state
// while the result slot is free, as the row rotates; an empty list gives one result.
// Next command transfer is taken once display ends and the result slot is free.
// Reset (synchronous, active low) empties the list; entry cells are not cleared.
module positional_list_insert_delete_top #(
    parameter int LIST_DEPTH = pli_pkg::LIST_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pli_in_if.sink    i_in,
    pli_out_if.source o_out
);
    import pli_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    t_dp_cmd                 dp_cmd;
    logic [CNT_W-1:0]        dp_count;
    logic signed [VAL_W-1:0] dp_head;

    pli_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .o_dp_cmd (dp_cmd),
        .i_count  (dp_count),
        .i_head   (dp_head)
    );

    pli_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_count (dp_count),
        .o_head  (dp_head)
    );

endmodule

// ----- rtl/core/pli_datapath.sv -----
// Datapath of the positional list: a row of entry cells that shift in
// parallel for insert, delete and display rotation, plus the entry count.
// Depends on pli_pkg.
module pli_datapath #(
    parameter int LIST_DEPTH = pli_pkg::LIST_DEPTH_DEF,
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pli_pkg::t_dp_cmd                i_cmd,
    output logic [CNT_W-1:0]                o_count,
    output logic signed [pli_pkg::VAL_W-1:0] o_head
);
    import pli_pkg::*;

    localparam int CMP_W = (CNT_W >= POS_W) ? CNT_W + 1 : POS_W + 1;

    logic signed [VAL_W-1:0] r_cells [LIST_DEPTH];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [CMP_W-1:0]        pos_x;
    logic [CMP_W-1:0]        cnt_x;

    assign pos_x = CMP_W'(i_cmd.pos);
    assign cnt_x = CMP_W'(r_count);

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == LIST_DEPTH - 1) ? g : g + 1;
        localparam logic [CMP_W-1:0] SLOT = CMP_W'(g + 1);

        logic signed [VAL_W-1:0] n_cell;

        always_comb begin
            n_cell = r_cells[g];
            case (i_cmd.op)
                DP_INSERT: begin
                    if (SLOT == pos_x) begin
                        n_cell = i_cmd.value;
                    end else if (SLOT > pos_x && SLOT <= cnt_x + CMP_W'(1)) begin
                        n_cell = r_cells[PREV];
                    end
                end
                DP_DELETE: begin
                    if (SLOT >= pos_x && SLOT < cnt_x) begin
                        n_cell = r_cells[NEXT];
                    end
                end
                DP_ROTATE: begin
                    if (SLOT < cnt_x) begin
                        n_cell = r_cells[NEXT];
                    end else if (SLOT == cnt_x) begin
                        n_cell = r_cells[0];
                    end
                end
                default: begin
                    n_cell = r_cells[g];
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_cells[g] <= n_cell;
        end
    end

    always_comb begin
        case (i_cmd.op)
            DP_INSERT: n_count = r_count + CNT_W'(1);
            DP_DELETE: n_count = r_count - CNT_W'(1);
            default:   n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_head  = r_cells[0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_insert_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_INSERT |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_delete_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_DELETE |-> r_count != '0)
        else $error("delete issued on empty list");

endmodule

// ----- rtl/core/pli_ctrl.sv -----
// Controller of the positional list: command decode and position checks,
// display sequencing, and the result output register.
// Depends on pli_pkg and the stream interfaces.
module pli_ctrl #(
    parameter int LIST_DEPTH = pli_pkg::LIST_DEPTH_DEF,
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pli_in_if.sink                           i_in,
    pli_out_if.source                        o_out,
    output pli_pkg::t_dp_cmd                 o_dp_cmd,
    input  logic [CNT_W-1:0]                 i_count,
    input  logic signed [pli_pkg::VAL_W-1:0] i_head
);
    import pli_pkg::*;

    localparam int CMP_W = (CNT_W >= POS_W) ? CNT_W + 1 : POS_W + 1;

    typedef enum logic {
        S_IDLE,
        S_DISP
    } t_state;

    t_state                  r_state,  n_state;
    logic [CNT_W-1:0]        r_idx,    n_idx;
    logic                    r_valid,  n_valid;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [CNT_OUT_W-1:0]    r_cnt,    n_cnt;
    logic signed [VAL_W-1:0] r_elem,   n_elem;
    logic                    r_evld,   n_evld;
    logic                    r_last,   n_last;

    logic             out_free;
    logic             in_take;
    logic             full;
    logic             ins_ok;
    logic             del_ok;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             disp_last;

    assign out_free  = !r_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_take   = i_in.valid && i_in.ready;

    assign pos_x  = CMP_W'(i_in.position);
    assign cnt_x  = CMP_W'(i_count);
    assign full   = (cnt_x == CMP_W'(LIST_DEPTH));
    assign ins_ok = !full && pos_x != '0 && pos_x <= cnt_x + CMP_W'(1);
    assign del_ok = pos_x != '0 && pos_x <= cnt_x;
    assign disp_last = (r_idx == i_count - CNT_W'(1));

    always_comb begin
        o_dp_cmd.op    = DP_NOP;
        o_dp_cmd.pos   = i_in.position;
        o_dp_cmd.value = i_in.value;
        n_state  = r_state;
        n_idx    = r_idx;
        n_valid  = r_valid && !o_out.ready;
        n_status = r_status;
        n_cnt    = r_cnt;
        n_elem   = r_elem;
        n_evld   = r_evld;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_elem = '0;
                    n_evld = 1'b0;
                    n_last = 1'b1;
                    n_cnt  = CNT_OUT_W'(i_count);
                    case (i_in.command)
                        CMD_INSERT: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (!ins_ok) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_status    = ST_OK;
                                n_cnt       = CNT_OUT_W'(i_count + CNT_W'(1));
                                o_dp_cmd.op = DP_INSERT;
                            end
                        end
                        CMD_DELETE: begin
                            n_valid = 1'b1;
                            if (!del_ok) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_status    = ST_OK;
                                n_cnt       = CNT_OUT_W'(i_count - CNT_W'(1));
                                o_dp_cmd.op = DP_DELETE;
                            end
                        end
                        CMD_DISPLAY: begin
                            n_status = ST_OK;
                            if (i_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_DISP;
                            end
                        end
                        default: begin
                            n_valid = r_valid && !o_out.ready;
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (out_free) begin
                    // head goes out, the row rotates so the next entry moves up
                    n_valid     = 1'b1;
                    n_status    = ST_OK;
                    n_cnt       = CNT_OUT_W'(i_count);
                    n_elem      = i_head;
                    n_evld      = 1'b1;
                    n_last      = disp_last;
                    n_idx       = r_idx + CNT_W'(1);
                    o_dp_cmd.op = DP_ROTATE;
                    if (disp_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        r_status <= n_status;
        r_cnt    <= n_cnt;
        r_elem   <= n_elem;
        r_evld   <= n_evld;
        r_last   <= n_last;
    end

    assign o_out.valid         = r_valid;
    assign o_out.status        = r_status;
    assign o_out.entry_count   = r_cnt;
    assign o_out.element       = r_elem;
    assign o_out.element_valid = r_evld;
    assign o_out.last          = r_last;

    a_disp_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DISP |-> !i_in.ready)
        else $error("input taken during display");

    a_op_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.op != DP_NOP |-> out_free)
        else $error("list changed while result slot busy");

    a_disp_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DISP |-> r_idx < i_count)
        else $error("display index past entry count");

endmodule

// ----- bench/positional_list_insert_delete_top_tb.sv -----
// Testbench for positional_list_insert_delete_top: directed and random
// insert/delete/display commands checked against an in-bench list predictor.
// Depends on pli_pkg, pli_stream_if and the positional list RTL.
`timescale 1ns / 1ps

module positional_list_insert_delete_top_tb;
    import pli_pkg::*;

    localparam int DEPTH = LIST_DEPTH_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [CMD_W-1:0]        command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        bit                      drain;
    } t_list_req;

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic [CNT_OUT_W-1:0]    entry_count;
        logic signed [VAL_W-1:0] element;
        logic                    element_valid;
        logic                    last;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pli_in_if  in_if ();
    pli_out_if out_if ();

    positional_list_insert_delete_top #(
        .LIST_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_list_req               pending_cmds[$];
    t_list_result            results_due[$];
    logic signed [VAL_W-1:0] list_cells[DEPTH];
    int                      list_len;
    int                      gen_len;
    int                      mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s at %0t: got %0h, expected %0h", what, $time, got, want);
        mismatch_count++;
    endtask

    task automatic push_result(input logic [STAT_W-1:0] status,
                               input logic signed [VAL_W-1:0] element,
                               input logic element_valid, input logic last);
        t_list_result r;
        r.status        = status;
        r.entry_count   = CNT_OUT_W'(list_len);
        r.element       = element;
        r.element_valid = element_valid;
        r.last          = last;
        results_due.push_back(r);
    endtask

    // list behavior for one accepted command
    task automatic apply_list_cmd(input t_list_req c);
        int k;
        int p;
        p = int'(c.position);
        case (c.command)
            CMD_INSERT: begin
                if (list_len >= DEPTH) begin
                    push_result(ST_FULL, '0, 1'b0, 1'b1);
                end else if (p < 1 || p > list_len + 1) begin
                    push_result(ST_BADPOS, '0, 1'b0, 1'b1);
                end else begin
                    for (k = list_len; k > p - 1; k--)
                        list_cells[k] = list_cells[k-1];
                    list_cells[p-1] = c.value;
                    list_len++;
                    push_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (p < 1 || p > list_len) begin
                    push_result(ST_BADPOS, '0, 1'b0, 1'b1);
                end else begin
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_cells[k] = list_cells[k+1];
                    list_len--;
                    push_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            CMD_DISPLAY: begin
                if (list_len == 0) begin
                    push_result(ST_OK, '0, 1'b0, 1'b1);
                end else begin
                    for (k = 0; k < list_len; k++)
                        push_result(ST_OK, list_cells[k], 1'b1, k + 1 == list_len);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_list_result want;
        if (results_due.size() == 0) begin
            report_mismatch("unexpected result, element", out_if.element, '0);
        end else begin
            want = results_due.pop_front();
            if (out_if.status !== want.status)
                report_mismatch("status", 32'(out_if.status), 32'(want.status));
            if (out_if.entry_count !== want.entry_count)
                report_mismatch("entry_count", 32'(out_if.entry_count),
                                32'(want.entry_count));
            if (out_if.element !== want.element)
                report_mismatch("element", out_if.element, want.element);
            if (out_if.element_valid !== want.element_valid)
                report_mismatch("element_valid", 32'(out_if.element_valid),
                                32'(want.element_valid));
            if (out_if.last !== want.last)
                report_mismatch("last", 32'(out_if.last), 32'(want.last));
        end
    endtask

    function automatic int pick_idle(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // generator side: tracks the list length to aim positions
    task automatic add_cmd(input logic [CMD_W-1:0] command, input int pos,
                           input logic signed [VAL_W-1:0] value);
        t_list_req c;
        c.command  = command;
        c.position = POS_W'(pos);
        c.value    = value;
        c.drain    = 1'b0;
        pending_cmds.push_back(c);
        if (command == CMD_INSERT && gen_len < DEPTH && pos >= 1 && pos <= gen_len + 1)
            gen_len++;
        else if (command == CMD_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    task automatic add_drain();
        t_list_req c;
        c.command  = CMD_UNUSED;
        c.position = '0;
        c.value    = '0;
        c.drain    = 1'b1;
        pending_cmds.push_back(c);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // driver
    t_list_req on_bus;
    int        tx_gap;
    bit        tx_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                apply_list_cmd(on_bus);
                tx_gap = pick_idle(tx_burst);
                if ($urandom_range(0, 99) < 4)
                    tx_burst = !tx_burst;
            end
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_cmds.size() > 0 && pending_cmds[0].drain) begin
                    in_if.valid <= 1'b0;
                    if (results_due.size() == 0)
                        void'(pending_cmds.pop_front());
                end else if (pending_cmds.size() > 0) begin
                    on_bus = pending_cmds.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.command  <= on_bus.command;
                    in_if.position <= on_bus.position;
                    in_if.value    <= on_bus.value;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int rx_stall;
    bit rx_burst;
    int n_stall;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_if.valid && out_if.ready)
                check_result();
            if ($urandom_range(0, 99) < 1)
                rx_burst = !rx_burst;
            if (rx_stall > 0) begin
                rx_stall--;
                out_if.ready <= 1'b0;
            end else begin
                n_stall = pick_idle(rx_burst);
                if (n_stall > 0) begin
                    rx_stall = n_stall - 1;
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int phase;
        int done;
        int r;
        int pos;
        logic [CMD_W-1:0] cmd;

        in_if.valid    = 1'b0;
        in_if.command  = CMD_INSERT;
        in_if.position = '0;
        in_if.value    = '0;
        out_if.ready   = 1'b0;
        gen_len        = 0;
        list_len       = 0;
        mismatch_count = 0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;

        // directed: empty list, edges of position, first/last/middle, unused command
        add_cmd(CMD_DISPLAY, 0, 0);
        add_cmd(CMD_DELETE, 1, 0);
        add_cmd(CMD_INSERT, 0, 1);
        add_cmd(CMD_INSERT, 2, 2);
        add_cmd(CMD_INSERT, 1, VAL_MIN);
        add_cmd(CMD_INSERT, 2, VAL_MAX);
        add_cmd(CMD_INSERT, 1, -32'sd1);
        add_cmd(CMD_INSERT, 2, 32'sd0);
        add_cmd(CMD_UNUSED, 1, 32'sh5a5a_5a5a);
        add_cmd(CMD_DELETE, 0, 0);
        add_cmd(CMD_DELETE, 5, 0);
        add_cmd(CMD_INSERT, 31, 3);
        add_cmd(CMD_DISPLAY, 31, -32'sd1);
        add_cmd(CMD_DELETE, 1, 0);
        add_cmd(CMD_DELETE, 3, 0);
        add_cmd(CMD_DELETE, 2, 0);
        add_cmd(CMD_DISPLAY, 0, 0);
        add_drain();

        // random phases alternate fill-heavy and drain-heavy
        for (phase = 0; phase < 6; phase++) begin
            done = 0;
            while (done < 50) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    add_cmd(CMD_UNUSED, $urandom_range(0, 31), $urandom);
                    continue;
                end
                if (r < 13)
                    cmd = CMD_DISPLAY;
                else if ((phase % 2 == 0) ? (r < 78) : (r < 33))
                    cmd = CMD_INSERT;
                else
                    cmd = CMD_DELETE;
                if ($urandom_range(0, 99) < 15 || cmd == CMD_DISPLAY)
                    pos = $urandom_range(0, 31);
                else if (cmd == CMD_INSERT)
                    pos = $urandom_range(1, (gen_len < DEPTH) ? gen_len + 1 : DEPTH + 1);
                else
                    pos = (gen_len == 0) ? $urandom_range(0, 31) : $urandom_range(1, gen_len);
                add_cmd(cmd, pos, pick_value());
                done++;
            end
            add_drain();
        end
        add_cmd(CMD_DISPLAY, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || in_if.valid)
            @(posedge i_clk);
        while (results_due.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
